>>> rtl/k_nearest_selector_assert.svh
// assertion macros used by the checker file knn_chk
`ifndef K_NEAREST_SELECTOR_ASSERT_SVH
`define K_NEAREST_SELECTOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define KNN_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("k_nearest_selector check failed");

// next-cycle implication, sampled on clk, off during reset
`define KNN_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("k_nearest_selector check failed");

`endif

>>> rtl/knn_pkg.sv
package knn_pkg;

    localparam int DIST_W  = 32;
    localparam int INDEX_W = 10;
    localparam int RANK_W  = 4;
    localparam int COUNT_W = 5;
    localparam int MAX_RESULTS = 16;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_INDEX    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBOR_COUNT = 1'b1;

    localparam logic [INDEX_W-1:0] QUERY_INDEX_RESET    = '0;
    localparam logic [COUNT_W-1:0] NEIGHBOR_COUNT_RESET = 5'd1;

    typedef enum logic [1:0] {
        ST_STREAM,
        ST_LOAD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic insert;
        logic load;
        logic shift;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic last;
    } status_t;

endpackage

>>> rtl/knn_ctrl.sv
module knn_ctrl
    import knn_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    input  logic    s_tlast,
    input  logic    m_tready,
    input  status_t stat,
    output logic    s_tready,
    output logic    m_tvalid,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_STREAM;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_STREAM:
            begin
                if (s_tvalid && s_tlast)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (m_tready && stat.last)
                begin
                    state_next = ST_STREAM;
                end
            end
            default:
            begin
                state_next = ST_STREAM;
            end
        endcase
    end

    always_comb
    begin
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_STREAM:
            begin
                s_tready   = 1'b1;
                cmd.insert = s_tvalid;
            end
            ST_LOAD:
            begin
                cmd.load = 1'b1;
            end
            ST_EMIT:
            begin
                m_tvalid  = 1'b1;
                cmd.shift = m_tready && !stat.last;
                cmd.clear = m_tready && stat.last;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> rtl/knn_dp.sv
module knn_dp
    import knn_pkg::*;
#(
    parameter int N_MAX = 1024,
    parameter int K_MAX = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    input  logic [DIST_W-1:0]     distance,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output status_t               stat,
    output logic [INDEX_W-1:0]    neighbor_index,
    output logic [RANK_W-1:0]     rank,
    output logic                  none_found
);

    localparam int POS_W  = (N_MAX > 2) ? $clog2(N_MAX) : 1;
    localparam int FILL_W = $clog2(K_MAX + 1);
    localparam int EXT_W  = POS_W + INDEX_W;
    localparam int CNT8_W = 8;

    // sorted candidate cells, nearest in cell 0
    logic [DIST_W-1:0]  dist_reg [K_MAX];
    logic [DIST_W-1:0]  dist_next [K_MAX];
    logic [INDEX_W-1:0] idx_reg [K_MAX];
    logic [INDEX_W-1:0] idx_next [K_MAX];
    logic [DIST_W-1:0]  dist_prev [K_MAX];
    logic [INDEX_W-1:0] idx_prev [K_MAX];
    logic [DIST_W-1:0]  dist_up [K_MAX];
    logic [INDEX_W-1:0] idx_up [K_MAX];

    logic [FILL_W-1:0]     filled_reg, filled_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [INDEX_W-1:0]    query_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic [RANK_W-1:0]     rank_reg, rank_next;
    logic [RANK_W-1:0]     last_rank_reg, last_rank_next;
    logic                  none_reg, none_next;

    logic [K_MAX-1:0]      take;
    logic [K_MAX-1:0]      prev_take;
    logic [EXT_W-1:0]      pos_ext;
    logic [EXT_W-1:0]      query_ext;
    logic [INDEX_W-1:0]    pos_index;
    logic                  candidate;
    logic [POS_W:0]        pos_inc;
    logic [CNT8_W-1:0]     n_count;

    assign pos_ext   = EXT_W'(pos_reg);
    assign query_ext = EXT_W'(query_reg);
    assign pos_index = pos_ext[INDEX_W-1:0];
    assign candidate = (pos_ext != query_ext) && (distance != '0);
    assign pos_inc   = {1'b0, pos_reg} + (POS_W+1)'(1);

    genvar g;
    for (g = 0; g < K_MAX; g++)
    begin : g_cell
        // a free cell or a farther entry takes the new candidate or the entry of the next-nearer cell
        assign take[g] = (FILL_W'(g) >= filled_reg) || (dist_reg[g] > distance);
        if (g == 0)
        begin : g_first
            assign prev_take[g] = 1'b0;
            assign dist_prev[g] = dist_reg[g];
            assign idx_prev[g]  = idx_reg[g];
        end
        else
        begin : g_rest
            assign prev_take[g] = take[g-1];
            assign dist_prev[g] = dist_reg[g-1];
            assign idx_prev[g]  = idx_reg[g-1];
        end
        if (g == K_MAX - 1)
        begin : g_top
            assign dist_up[g] = dist_reg[g];
            assign idx_up[g]  = idx_reg[g];
        end
        else
        begin : g_mid
            assign dist_up[g] = dist_reg[g+1];
            assign idx_up[g]  = idx_reg[g+1];
        end
    end

    always_comb
    begin
        for (int j = 0; j < K_MAX; j++)
        begin
            dist_next[j] = dist_reg[j];
            idx_next[j]  = idx_reg[j];
            if (cmd.insert && candidate)
            begin
                if (prev_take[j])
                begin
                    dist_next[j] = dist_prev[j];
                    idx_next[j]  = idx_prev[j];
                end
                else if (take[j])
                begin
                    dist_next[j] = distance;
                    idx_next[j]  = pos_index;
                end
            end
            else if (cmd.shift)
            begin
                dist_next[j] = dist_up[j];
                idx_next[j]  = idx_up[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < K_MAX; j++)
        begin
            dist_reg[j] <= dist_next[j];
            idx_reg[j]  <= idx_next[j];
        end
    end

    always_comb
    begin
        filled_next = filled_reg;
        pos_next    = pos_reg;
        if (cmd.clear)
        begin
            filled_next = '0;
            pos_next    = '0;
        end
        else if (cmd.insert)
        begin
            if (candidate && (filled_reg < FILL_W'(K_MAX)))
            begin
                filled_next = filled_reg + FILL_W'(1);
            end
            pos_next = (pos_inc >= (POS_W+1)'(N_MAX)) ? '0 : pos_inc[POS_W-1:0];
        end
    end

    // results = min(neighbor_count, K_MAX, filled, MAX_RESULTS)
    always_comb
    begin
        n_count = CNT8_W'(count_reg);
        if (n_count > CNT8_W'(K_MAX))
        begin
            n_count = CNT8_W'(K_MAX);
        end
        if (n_count > CNT8_W'(filled_reg))
        begin
            n_count = CNT8_W'(filled_reg);
        end
        if (n_count > CNT8_W'(MAX_RESULTS))
        begin
            n_count = CNT8_W'(MAX_RESULTS);
        end
    end

    always_comb
    begin
        rank_next      = rank_reg;
        last_rank_next = last_rank_reg;
        none_next      = none_reg;
        if (cmd.load)
        begin
            rank_next      = '0;
            none_next      = (n_count == '0);
            last_rank_next = RANK_W'(n_count - CNT8_W'(1));
        end
        else if (cmd.shift)
        begin
            rank_next = rank_reg + RANK_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg    <= '0;
            pos_reg       <= '0;
            rank_reg      <= '0;
            last_rank_reg <= '0;
            none_reg      <= 1'b0;
            query_reg     <= QUERY_INDEX_RESET;
            count_reg     <= NEIGHBOR_COUNT_RESET;
        end
        else
        begin
            filled_reg    <= filled_next;
            pos_reg       <= pos_next;
            rank_reg      <= rank_next;
            last_rank_reg <= last_rank_next;
            none_reg      <= none_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_QUERY_INDEX:    query_reg <= cfg_data[INDEX_W-1:0];
                    CFG_NEIGHBOR_COUNT: count_reg <= cfg_data[COUNT_W-1:0];
                    default:            query_reg <= query_reg;
                endcase
            end
        end
    end

    assign stat.last      = none_reg || (rank_reg == last_rank_reg);
    assign neighbor_index = none_reg ? '0 : idx_reg[0];
    assign rank           = rank_reg;
    assign none_found     = none_reg;

endmodule

>>> rtl/k_nearest_selector.sv
// channel   dir  tdata / data                          tuser / extra   tlast
// s_*       in   [31:0] distance                       -               row_end
// m_*       out  [9:0] neighbor_index, [13:10] rank    [0] none_found  is_last
// cfg_*     in   cfg_index 0 query_index, 1 neighbor_count; cfg_data value
//
// one distance item per cycle while a row streams: every item is inserted
// by K_MAX parallel compare-and-shift cells
// after the row_end item: a load state sizes the result run, then one result per
// cycle while m_tready is high; s_tready stays low until the last result is taken
// reset (rst_n low, asynchronous) empties the list and sets query_index 0,
// neighbor_count 1; no clearing pass, cell contents are never read unfilled
// a stalled result holds its data; cfg_ready is always high
module k_nearest_selector
    import knn_pkg::*;
#(
    parameter int N_MAX = 1024,
    parameter int K_MAX = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // distance items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,    // [31:0] distance
    input  logic                  s_tlast,    // row_end
    // result items
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,    // [9:0] neighbor_index, [13:10] rank, zero pad
    output logic [0:0]            m_tuser,    // [0] none_found
    output logic                  m_tlast,    // is_last
    // register writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t               cmd;
    status_t            stat;
    logic [INDEX_W-1:0] neighbor_index;
    logic [RANK_W-1:0]  rank;
    logic               none_found;

    // register writes land in any cycle
    assign cfg_ready = 1'b1;

    knn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .m_tready (m_tready),
        .stat     (stat),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    knn_dp #(
        .N_MAX (N_MAX),
        .K_MAX (K_MAX)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .distance       (s_tdata),
        .cfg_write      (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .stat           (stat),
        .neighbor_index (neighbor_index),
        .rank           (rank),
        .none_found     (none_found)
    );

    // pack the result item, is_last follows the run length or the empty case
    assign m_tdata = {2'b00, rank, neighbor_index};
    assign m_tuser = none_found;
    assign m_tlast = stat.last;

endmodule

>>> rtl/knn_chk.sv
`include "k_nearest_selector_assert.svh"

module knn_chk
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        m_tlast
);

    // an empty result is a single item with zero index and rank
    `KNN_ASSERT_NOW(a_none_alone, m_tvalid && m_tuser[0], m_tlast && (m_tdata == 16'd0))

    // no distance item is taken while results are pending
    `KNN_ASSERT_NOW(a_no_overlap, s_tvalid && s_tready, !m_tvalid)

    // results of one run follow back to back with rising rank
    `KNN_ASSERT_NEXT(a_rank_step, m_tvalid && m_tready && !m_tlast, m_tvalid && (m_tdata[13:10] == ($past(m_tdata[13:10]) + 4'd1)))

    // a stalled result holds
    `KNN_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

endmodule

bind k_nearest_selector knn_chk u_knn_chk (.*);

>>> tb/tb.sv
module tb
    import knn_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // list depth of the block, equal to its K_MAX parameter
    localparam int KEEP_MAX = 16;
    // cycles waited after the last result before a register write
    localparam int SETTLE_CYCLES = 4;
    // long receiver hold-off, in cycles
    localparam int LONG_HOLD = 300;
    // random items wanted, and where the quiet stretch at the end begins
    localparam int RANDOM_ITEMS = 320;
    localparam int QUIET_FROM = 280;

    typedef struct packed {
        logic                 is_last;
        logic                 none_found;
        logic [RANK_W-1:0]    rank;
        logic [INDEX_W-1:0]   idx;
    } neighbor_t;

    typedef enum logic {
        STEP_ITEM,
        STEP_CFG
    } step_kind_t;

    // one row of the directed table: a distance item or a register write
    typedef struct packed {
        step_kind_t           kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [31:0]          value;
        logic                 row_end;
        logic                 typed;
        neighbor_t            want;
    } step_t;

    localparam neighbor_t NO_NEIGHBOR = '{1'b1, 1'b1, 4'd0, 10'd0};
    localparam neighbor_t NO_CHECK    = '0;

    // directed stimulus, walked in order
    localparam step_t DIRECTED_STEPS [32] = '{
        // after reset: query 0, one neighbor; the only item is the query itself
        '{STEP_ITEM, CFG_QUERY_INDEX, 32'd5, 1'b1, 1'b1, NO_NEIGHBOR},
        // query entry skipped, largest distance loses to a small one
        '{STEP_ITEM, CFG_QUERY_INDEX, 32'h0000_0001, 1'b0, 1'b0, NO_CHECK},
        '{STEP_ITEM, CFG_QUERY_INDEX, 32'hFFFF_FFFF, 1'b0, 1'b0, NO_CHECK},
        '{STEP_ITEM, CFG_QUERY_INDEX, 32'h0000_0010, 1'b1, 1'b1,
          '{1'b1, 1'b0, 4'd0, 10'd2}},
        // zero neighbors wanted
        '{STEP_CFG, CFG_NEIGHBOR_COUNT, 32'd0, 1'b0, 1'b0, NO_CHECK},
        '{STEP_ITEM, CFG_QUERY_INDEX, 32'd7, 1'b0, 1'b0, NO_CHECK},
        '{STEP_ITEM, CFG_QUERY_INDEX, 32'd9, 1'b1, 1'b1, NO_NEIGHBOR},
        // query out of reach, zero distance skipped, ties in index order
        '{STEP_CFG, CFG_QUERY_INDEX, 32'd1023, 1'b0, 1'b0, NO_CHECK},
        '{STEP_CFG, CFG_NEIGHBOR_COUNT, 32'd16, 1'b0, 1'b0, NO_CHECK},
        '{STEP_ITEM, CFG_QUERY_INDEX, 32'd3, 1'b0, 1'b0, NO_CHECK},
        '{STEP_ITEM, CFG_QUERY_INDEX, 32'd0, 1'b0, 1'b0, NO_CHECK},
        '{STEP_ITEM, CFG_QUERY_INDEX, 32'd3, 1'b0, 1'b0, NO_CHECK},
        '{STEP_ITEM, CFG_QUERY_INDEX, 32'd1, 1'b1, 1'b0, NO_CHECK},
        // count above the list depth saturates; list fills, drops, then evicts
        '{STEP_CFG, CFG_NEIGHBOR_COUNT, 32'd31, 1'b0, 1'b0, NO_CHECK},
        '{STEP_ITEM, CFG_QUERY_INDEX, 32'd9, 1'b0, 1'b0, NO_CHECK},
        '{STEP_ITEM, CFG_QUERY_INDEX, 32'd8, 1'b0, 1'b0, NO_CHECK},
        '{STEP_ITEM, CFG_QUERY_INDEX, 32'd7, 1'b0, 1'b0, NO_CHECK},
        '{STEP_ITEM, CFG_QUERY_INDEX, 32'd7, 1'b0, 1'b0, NO_CHECK},
        '{STEP_ITEM, CFG_QUERY_INDEX, 32'd6, 1'b0, 1'b0, NO_CHECK},
        '{STEP_ITEM, CFG_QUERY_INDEX, 32'd5, 1'b0, 1'b0, NO_CHECK},
        '{STEP_ITEM, CFG_QUERY_INDEX, 32'd4, 1'b0, 1'b0, NO_CHECK},
        '{STEP_ITEM, CFG_QUERY_INDEX, 32'd3, 1'b0, 1'b0, NO_CHECK},
        '{STEP_ITEM, CFG_QUERY_INDEX, 32'd2, 1'b0, 1'b0, NO_CHECK},
        '{STEP_ITEM, CFG_QUERY_INDEX, 32'd2, 1'b0, 1'b0, NO_CHECK},
        '{STEP_ITEM, CFG_QUERY_INDEX, 32'd1, 1'b0, 1'b0, NO_CHECK},
        '{STEP_ITEM, CFG_QUERY_INDEX, 32'h0002_0000, 1'b0, 1'b0, NO_CHECK},
        '{STEP_ITEM, CFG_QUERY_INDEX, 32'h0001_0000, 1'b0, 1'b0, NO_CHECK},
        '{STEP_ITEM, CFG_QUERY_INDEX, 32'd5, 1'b0, 1'b0, NO_CHECK},
        '{STEP_ITEM, CFG_QUERY_INDEX, 32'd3, 1'b0, 1'b0, NO_CHECK},
        '{STEP_ITEM, CFG_QUERY_INDEX, 32'd1, 1'b0, 1'b0, NO_CHECK},
        '{STEP_ITEM, CFG_QUERY_INDEX, 32'hFFFF_FFFF, 1'b0, 1'b0, NO_CHECK},
        '{STEP_ITEM, CFG_QUERY_INDEX, 32'd1, 1'b1, 1'b0, NO_CHECK}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [31:0]           s_tdata;    // [31:0] distance
    logic                  s_tlast;    // row_end
    logic                  m_tvalid;
    logic                  m_tready;
    logic [15:0]           m_tdata;    // [9:0] neighbor_index, [13:10] rank, zero pad
    logic [0:0]            m_tuser;    // [0] none_found
    logic                  m_tlast;    // is_last
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predictor copy of the block state and registers
    logic [31:0]          kept_dist [KEEP_MAX];
    logic [INDEX_W-1:0]   kept_index [KEEP_MAX];
    int                   kept_count;
    logic [INDEX_W-1:0]   row_pos;
    logic [INDEX_W-1:0]   query_sel;
    logic [COUNT_W-1:0]   want_count;

    neighbor_t            row_results [$];        // results of the latest item
    neighbor_t            pending_neighbors [$];  // results still to come
    int                   mismatch_count;
    int                   random_items;
    bit                   quiet;                  // no idling on either side
    int                   hold_requests;          // asked by stimulus
    int                   holds_done;             // served by the receiver

    k_nearest_selector u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void note_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s", $realtime, msg);
    endfunction

    // insertion list update for one distance item, row results on row end
    function automatic void predict_neighbors(logic [31:0] d, logic row_end);
        int        slot;
        int        j;
        int        k;
        int        n;
        neighbor_t nb;
        row_results.delete();
        if (row_pos != query_sel && d != 32'd0)
        begin
            slot = 0;
            while (slot < kept_count && kept_dist[slot] <= d)
                slot++;
            // a candidate not strictly nearer than the farthest of a full list is dropped
            if (slot < KEEP_MAX)
            begin
                j = (kept_count < KEEP_MAX) ? kept_count : KEEP_MAX - 1;
                while (j > slot)
                begin
                    kept_dist[j]  = kept_dist[j-1];
                    kept_index[j] = kept_index[j-1];
                    j--;
                end
                kept_dist[slot]  = d;
                kept_index[slot] = row_pos;
                if (kept_count < KEEP_MAX)
                    kept_count++;
            end
        end
        // ten bits wrap exactly at N_MAX
        row_pos = row_pos + 1'b1;
        if (row_end)
        begin
            k = (want_count > KEEP_MAX) ? KEEP_MAX : int'(want_count);
            n = (k < kept_count) ? k : kept_count;
            if (n > MAX_RESULTS)
                n = MAX_RESULTS;
            if (n == 0)
                row_results.insert(row_results.size(), NO_NEIGHBOR);
            else
            begin
                for (int r = 0; r < n; r++)
                begin
                    nb.idx        = kept_index[r];
                    nb.rank       = r[RANK_W-1:0];
                    nb.none_found = 1'b0;
                    nb.is_last    = (r + 1 == n);
                    row_results.insert(row_results.size(), nb);
                end
            end
            kept_count = 0;
            row_pos    = '0;
        end
    endfunction

    // offer one distance item, optionally after a random idle burst
    task automatic send_item(input logic [31:0] d, input logic row_end, input bit may_idle,
                             input bit typed, input neighbor_t want);
        int gap;
        if (may_idle && !quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 6);
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= row_end;
        do @(posedge clk); while (!s_tready);
        predict_neighbors(d, row_end);
        if (typed)
            pending_neighbors.insert(pending_neighbors.size(), want);
        else
            foreach (row_results[i])
                pending_neighbors.insert(pending_neighbors.size(), row_results[i]);
    endtask

    // stop offering, let every expected result drain, then settle
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_neighbors.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_QUERY_INDEX)
            query_sel = val;
        else
            want_count = val[COUNT_W-1:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_distance(int mode);
        logic [31:0] d;
        case (mode)
            0: d = $urandom_range(1, 6);                      // many ties
            1: d = $urandom;
            2: d = $urandom_range(1, 65536);
            default: d = $urandom_range(0, 1) ? 32'hFFFF_FFFF - $urandom_range(0, 3)
                                               : $urandom_range(1, 3);
        endcase
        if ($urandom_range(0, 7) == 0)
            d = 32'd0;
        return d;
    endfunction

    // result checker: every accepted result against the oldest expectation
    always @(posedge clk)
    begin
        neighbor_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_neighbors.size() == 0)
                note_mismatch($sformatf("unexpected result tdata=%h tuser=%b tlast=%b",
                                        m_tdata, m_tuser, m_tlast));
            else
            begin
                e = pending_neighbors.pop_front();
                if (m_tdata !== {2'b00, e.rank, e.idx} || m_tuser[0] !== e.none_found
                    || m_tlast !== e.is_last)
                    note_mismatch($sformatf(
                        "exp idx=%0d rank=%0d none=%b last=%b got tdata=%h tuser=%b tlast=%b",
                        e.idx, e.rank, e.none_found, e.is_last, m_tdata, m_tuser, m_tlast));
            end
        end
    end

    // receiver: random idle bursts, one long hold-off when asked, none at the end
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (holds_done < hold_requests)
            begin
                holds_done++;
                m_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 5)) @(negedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // run limit
    initial
    begin
        #4000000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int len;
        int mode;
        int pick;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        rst_n      = 1'b0;
        kept_count = 0;
        row_pos    = '0;
        query_sel  = QUERY_INDEX_RESET;
        want_count = NEIGHBOR_COUNT_RESET;
        mismatch_count = 0;
        random_items   = 0;
        quiet          = 1'b0;
        hold_requests  = 0;
        holds_done     = 0;
        foreach (kept_dist[i])
        begin
            kept_dist[i]  = '0;
            kept_index[i] = '0;
        end
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // directed table
        for (int s = 0; s < $size(DIRECTED_STEPS); s++)
        begin
            if (DIRECTED_STEPS[s].kind == STEP_CFG)
            begin
                wait_drained();
                write_reg(DIRECTED_STEPS[s].reg_idx,
                          DIRECTED_STEPS[s].value[CFG_DATA_W-1:0]);
            end
            else
                send_item(DIRECTED_STEPS[s].value, DIRECTED_STEPS[s].row_end, 1'b1,
                          DIRECTED_STEPS[s].typed, DIRECTED_STEPS[s].want);
        end

        // back pressure: receiver holds off while rows keep coming back to back
        wait_drained();
        write_reg(CFG_QUERY_INDEX, 10'd5);
        write_reg(CFG_NEIGHBOR_COUNT, 10'd16);
        hold_requests++;
        for (int r = 0; r < 3; r++)
            for (int i = 0; i < 20; i++)
                send_item(pick_distance(r), i == 19, 1'b0, 1'b0, NO_CHECK);

        // random rows with occasional register changes between them
        while (random_items < RANDOM_ITEMS)
        begin
            len  = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
            mode = $urandom_range(0, 3);
            if ($urandom_range(0, 2) == 0)
            begin
                wait_drained();
                pick = $urandom_range(0, 2);
                if (pick != 1)
                begin
                    case ($urandom_range(0, 3))
                        0: write_reg(CFG_QUERY_INDEX, CFG_DATA_W'($urandom_range(0, 1023)));
                        1: write_reg(CFG_QUERY_INDEX, 10'd1023);
                        default: write_reg(CFG_QUERY_INDEX, CFG_DATA_W'($urandom_range(0, len)));
                    endcase
                end
                if (pick != 0)
                begin
                    case ($urandom_range(0, 6))
                        0: write_reg(CFG_NEIGHBOR_COUNT, 10'd0);
                        1: write_reg(CFG_NEIGHBOR_COUNT, 10'd1);
                        2: write_reg(CFG_NEIGHBOR_COUNT, 10'd16);
                        3: write_reg(CFG_NEIGHBOR_COUNT, 10'd31);
                        6: write_reg(CFG_NEIGHBOR_COUNT,
                                     CFG_DATA_W'($urandom_range(0, 1023)));
                        default: write_reg(CFG_NEIGHBOR_COUNT,
                                           CFG_DATA_W'($urandom_range(0, 31)));
                    endcase
                end
            end
            for (int i = 0; i < len; i++)
            begin
                if (random_items >= QUIET_FROM)
                    quiet = 1'b1;
                send_item(pick_distance(mode), i == len - 1, 1'b1, 1'b0, NO_CHECK);
                random_items++;
            end
        end

        // drain, then watch a little longer for stray results
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_neighbors.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && pending_neighbors.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/knn_pkg.sv
rtl/knn_ctrl.sv
rtl/knn_dp.sv
rtl/k_nearest_selector.sv
rtl/knn_chk.sv
tb/tb.sv
